// ----- rtl/core/rms_pkg.sv -----
// Shared types, widths and constants of the running mean and deviation block.
package rms_pkg;

    // Series capacity and field widths
    localparam int MAX_SAMPLES = 65536;
    localparam int SAMPLE_W    = 16;
    localparam int CNT_W       = 17;
    localparam int SUM_W       = 33;
    localparam int SUMSQ_W     = 48;
    localparam int SQ_W        = 31;
    localparam int MEAN_W      = 32;
    localparam int STDEV_W     = 32;

    // Back-end arithmetic widths
    localparam int MAG_W       = 32;
    localparam int WIDE_W      = 63;
    localparam int DVD_W       = 95;
    localparam int DVS_W       = 32;
    localparam int QUO_W       = 64;
    localparam int STEP_W      = 7;
    localparam int MEAN_STEPS  = 48;
    localparam int VAR_STEPS   = 95;
    localparam int RAD_W       = 64;
    localparam int ROOT_W      = 32;
    localparam int SQRT_STEPS  = 32;
    localparam int SQRT_CNT_W  = 6;

    // Smallest deviation reported, one LSB
    localparam logic [STDEV_W-1:0] STDEV_FLOOR = STDEV_W'(1);

    // Series record handed from the front end to the back end
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [SUMSQ_W-1:0] sumsq;
        logic [CNT_W-1:0]   n;
        logic               drop;
    } rms_rec_t;

    // Queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } rms_qstat_t;

    // One finished result
    typedef struct packed {
        logic [MEAN_W-1:0]  mean;
        logic [STDEV_W-1:0] stdev;
        logic [CNT_W-1:0]   count;
        logic               overflow;
    } rms_res_t;

    // Back-end sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_MULT,
        S_DIFF,
        S_MDIV,
        S_VDIV,
        S_SQRT,
        S_DONE
    } rms_state_t;

    // Steps of the shared multiplier
    typedef enum logic [2:0] {
        MS_NSQ0,
        MS_NSQ1,
        MS_NSQ2,
        MS_MAGSQ,
        MS_PAIR
    } rms_mstep_t;

endpackage

// ----- rtl/core/rms_front.sv -----
// Front end: take samples, square them and accumulate count, sum and sum of squares.
module rms_front import rms_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic                       s_last,
    output logic                       push,
    output rms_rec_t                   push_rec,
    input  rms_qstat_t                 qstat
);

    logic                       st1_valid_reg;
    logic                       st1_last_reg;
    logic signed [SAMPLE_W-1:0] st1_val_reg;
    logic [SQ_W-1:0]            st1_sq_reg;

    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [SUM_W-1:0]   sum_reg,   sum_next;
    logic [SUMSQ_W-1:0] sumsq_reg, sumsq_next;
    logic               drop_reg,  drop_next;

    logic signed [2*SAMPLE_W-1:0] sq_full;
    logic                         stall;
    logic                         s_fire;
    logic                         st1_fire;
    logic                         take;

    assign sq_full  = s_sample * s_sample;
    // hold the marked item while no queue slot is free
    assign stall    = st1_valid_reg && st1_last_reg && qstat.full;
    assign s_ready  = !stall;
    assign s_fire   = s_valid && s_ready;
    assign st1_fire = st1_valid_reg && !stall;
    assign take     = cnt_reg < CNT_W'(MAX_SAMPLES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            st1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st1_last_reg <= s_last;
            st1_val_reg  <= s_sample;
            st1_sq_reg   <= sq_full[SQ_W-1:0];
        end
    end

    always_comb begin
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        sumsq_next = sumsq_reg;
        drop_next  = drop_reg;
        push       = 1'b0;
        if (st1_fire) begin
            if (take) begin
                cnt_next   = cnt_reg + CNT_W'(1);
                sum_next   = sum_reg + {{(SUM_W-SAMPLE_W){st1_val_reg[SAMPLE_W-1]}}, st1_val_reg};
                sumsq_next = sumsq_reg + {{(SUMSQ_W-SQ_W){1'b0}}, st1_sq_reg};
            end else begin
                drop_next = 1'b1;
            end
        end
        push_rec.sum   = sum_next;
        push_rec.sumsq = sumsq_next;
        push_rec.n     = cnt_next;
        push_rec.drop  = drop_next;
        if (st1_fire && st1_last_reg) begin
            // hand the series over and start afresh
            push       = 1'b1;
            cnt_next   = '0;
            sum_next   = '0;
            sumsq_next = '0;
            drop_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            sumsq_reg <= sumsq_next;
            drop_reg  <= drop_next;
        end
    end

endmodule

// ----- rtl/core/rms_queue.sv -----
// Two-entry queue of finished series records between front and back end.
module rms_queue import rms_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  rms_rec_t   push_rec,
    input  logic       pop,
    output rms_rec_t   pop_rec,
    output rms_qstat_t qstat
);

    rms_rec_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg, fill_next;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    assign pop_rec     = entry_reg[rd_ptr_reg];
    assign qstat.full  = fill_reg == 2'd2;
    assign qstat.empty = fill_reg == 2'd0;

    always_comb begin
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

// ----- rtl/core/rms_div.sv -----
// Restoring divider, one quotient bit per cycle, dividend left aligned.
module rms_div import rms_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DVS_W-1:0]  divisor,
    input  logic [STEP_W-1:0] steps,
    output logic              done,
    output logic [QUO_W-1:0]  quo,
    output logic [DVS_W-1:0]  rem
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           qbit;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign qbit  = trial >= {1'b0, dvs_reg};

    always_comb begin
        if (qbit) begin
            rem_next = diff[DVS_W-1:0];
        end else begin
            rem_next = trial[DVS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QUO_W-2:0], qbit};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ----- rtl/core/rms_sqrt.sv -----
// Integer square root, one result bit per cycle.
module rms_sqrt import rms_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic [RAD_W-1:0]      rad_reg;
    logic [ROOT_W:0]       rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg;

    logic [ROOT_W+2:0] part;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] diff;
    logic              rbit;

    // bring down two radicand bits, try root*4+1
    assign part  = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign diff  = part - trial;
    assign rbit  = part >= trial;

    always_comb begin
        if (rbit) begin
            rem_next = diff[ROOT_W:0];
        end else begin
            rem_next = part[ROOT_W:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= SQRT_CNT_W'(SQRT_STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - SQRT_CNT_W'(1);
                if (cnt_reg == SQRT_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= {root_reg[ROOT_W-2:0], rbit};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- rtl/core/rms_back.sv -----
// Back end: turn one series record into mean and deviation, hold the result.
module rms_back import rms_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  rms_qstat_t qstat,
    input  rms_rec_t   pop_rec,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output rms_res_t   out_res
);

    rms_state_t state_reg, state_next;
    rms_mstep_t mstep_reg;

    logic                 neg_reg;
    logic [MAG_W-1:0]     mag_reg;
    logic [SUMSQ_W-1:0]   sumsq_reg;
    logic [CNT_W-1:0]     n_reg;
    logic                 drop_reg;
    logic [WIDE_W-1:0]    nsq_reg;
    logic [WIDE_W-1:0]    magsq_reg;
    logic [DVS_W-1:0]     m_reg;
    logic [WIDE_W-1:0]    d_reg;
    logic                 trivial_reg;
    logic [MEAN_W-1:0]    mean_reg;
    logic [STDEV_W-1:0]   stdev_reg;
    logic                 out_valid_reg;
    rms_res_t             out_res_reg;

    logic [SUM_W-1:0]     sum_neg;
    logic [MAG_W-1:0]     mul_a;
    logic [MAG_W-1:0]     mul_b;
    logic [2*MAG_W-1:0]   prod;
    logic                 out_free;
    logic                 out_load;
    logic                 div_start;
    logic [DVD_W-1:0]     div_dividend;
    logic [DVS_W-1:0]     div_divisor;
    logic [STEP_W-1:0]    div_steps;
    logic                 div_done;
    logic [QUO_W-1:0]     div_quo;
    logic [DVS_W-1:0]     div_rem;
    logic                 sqrt_start;
    logic                 sqrt_done;
    logic [ROOT_W-1:0]    sqrt_root;
    logic [MEAN_STEPS-1:0] ceil_q;
    logic [MEAN_STEPS-1:0] neg_q;

    assign sum_neg  = ~pop_rec.sum + SUM_W'(1);
    assign out_free = !out_valid_reg || out_ready;
    // round the magnitude up for a negative sum, then negate
    assign ceil_q   = div_quo[MEAN_STEPS-1:0] + MEAN_STEPS'(div_rem != '0);
    assign neg_q    = ~ceil_q + MEAN_STEPS'(1);

    // one shared multiplier, operands by step
    always_comb begin
        case (mstep_reg)
            MS_NSQ0: begin
                mul_a = MAG_W'(n_reg);
                mul_b = MAG_W'(sumsq_reg[15:0]);
            end
            MS_NSQ1: begin
                mul_a = MAG_W'(n_reg);
                mul_b = MAG_W'(sumsq_reg[31:16]);
            end
            MS_NSQ2: begin
                mul_a = MAG_W'(n_reg);
                mul_b = MAG_W'(sumsq_reg[47:32]);
            end
            MS_MAGSQ: begin
                mul_a = mag_reg;
                mul_b = mag_reg;
            end
            MS_PAIR: begin
                mul_a = MAG_W'(n_reg);
                mul_b = MAG_W'(n_reg - CNT_W'(1));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (!qstat.empty) begin
                    state_next = S_MULT;
                end
            end
            S_MULT: begin
                if (mstep_reg == MS_PAIR) begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF: state_next = S_MDIV;
            S_MDIV: begin
                if (div_done) begin
                    state_next = trivial_reg ? S_DONE : S_VDIV;
                end
            end
            S_VDIV: begin
                if (div_done) begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sqrt_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        pop          = 1'b0;
        div_start    = 1'b0;
        div_dividend = {d_reg, 32'b0};
        div_divisor  = m_reg;
        div_steps    = STEP_W'(VAR_STEPS);
        sqrt_start   = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            S_IDLE: pop = !qstat.empty;
            S_DIFF: begin
                div_start    = 1'b1;
                div_dividend = {mag_reg, 16'b0, 47'b0};
                div_divisor  = DVS_W'(n_reg);
                div_steps    = STEP_W'(MEAN_STEPS);
            end
            S_MDIV: div_start = div_done && !trivial_reg;
            S_VDIV: sqrt_start = div_done;
            S_DONE: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (pop) begin
                    neg_reg   <= pop_rec.sum[SUM_W-1];
                    mag_reg   <= pop_rec.sum[SUM_W-1] ? sum_neg[MAG_W-1:0]
                                                      : pop_rec.sum[MAG_W-1:0];
                    sumsq_reg <= pop_rec.sumsq;
                    n_reg     <= pop_rec.n;
                    drop_reg  <= pop_rec.drop;
                    mstep_reg <= MS_NSQ0;
                end
            end
            S_MULT: begin
                case (mstep_reg)
                    MS_NSQ0: begin
                        nsq_reg   <= prod[WIDE_W-1:0];
                        mstep_reg <= MS_NSQ1;
                    end
                    MS_NSQ1: begin
                        nsq_reg   <= nsq_reg + {prod[WIDE_W-17:0], 16'b0};
                        mstep_reg <= MS_NSQ2;
                    end
                    MS_NSQ2: begin
                        nsq_reg   <= nsq_reg + {prod[WIDE_W-33:0], 32'b0};
                        mstep_reg <= MS_MAGSQ;
                    end
                    MS_MAGSQ: begin
                        magsq_reg <= prod[WIDE_W-1:0];
                        mstep_reg <= MS_PAIR;
                    end
                    MS_PAIR: m_reg <= prod[DVS_W-1:0];
                    default: mstep_reg <= MS_NSQ0;
                endcase
            end
            S_DIFF: begin
                trivial_reg <= (n_reg < CNT_W'(2)) || (nsq_reg <= magsq_reg);
                d_reg       <= nsq_reg - magsq_reg;
            end
            S_MDIV: begin
                if (div_done) begin
                    mean_reg <= neg_reg ? neg_q[MEAN_W-1:0] : div_quo[MEAN_W-1:0];
                    if (trivial_reg) begin
                        stdev_reg <= STDEV_FLOOR;
                    end
                end
            end
            S_SQRT: begin
                if (sqrt_done) begin
                    stdev_reg <= (sqrt_root == '0) ? STDEV_FLOOR : sqrt_root;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_res_reg.mean     <= mean_reg;
            out_res_reg.stdev    <= stdev_reg;
            out_res_reg.count    <= n_reg;
            out_res_reg.overflow <= drop_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    rms_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .done     (div_done),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    rms_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (div_quo),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

endmodule

// ----- rtl/core/running_mean_stdev.sv -----
// Top level of the running mean and sample standard deviation block.
//
// Input channel (s_): one signed 16-bit sample per item in s_tdata, s_tlast marks
// the final sample of a series. Result channel (m_): one item per series carrying
// the mean and sample deviation (16 fractional bits each), the sample count and a
// flag that samples beyond the 65536-sample capacity were dropped.
// Throughput: the front end takes one sample every cycle, except that a last sample
// waits while the queue is full. The back end works through each series in set-up
// and multiply steps, a 48-step and a 95-step restoring divide and a 32-step square
// root, one bit per cycle; a series with a single sample or zero spread skips the
// second divide and the root.
// A two-entry queue of finished series sits between the two ends, so short series
// keep flowing until two finished series wait in the queue; then s_tready drops
// on a last sample.
// When the receiver stalls the result holds in the output register and the back
// end parks its next result until the register frees.
// Reset (aresetn low at a clock edge) empties the pipeline, the queue and the
// accumulators and drops any pending result.
module running_mean_stdev import rms_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // [31:0] mean, [63:32] stdev, [80:64] count,
                                   // [81] overflow, [87:82] zero
);

    logic       push;
    rms_rec_t   push_rec;
    logic       pop;
    rms_rec_t   pop_rec;
    rms_qstat_t qstat;
    rms_res_t   res;

    // accumulate samples, hand over one record per series
    rms_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_sample (s_tdata),
        .s_last   (s_tlast),
        .push     (push),
        .push_rec (push_rec),
        .qstat    (qstat)
    );

    // decouple the two ends
    rms_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .qstat    (qstat)
    );

    // divide, take the root and hold the result item
    rms_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .qstat     (qstat),
        .pop_rec   (pop_rec),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {6'b0, res.overflow, res.count, res.stdev, res.mean};

endmodule

// ----- rtl/core/rms_checker.sv -----
// Port-level checks on the running mean and deviation block, bound to the top level.
module rms_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // deviation never below one LSB
    a_stdev_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[63:32] != 32'd0)
        else $error("deviation below one LSB");

    // count within one and capacity
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[80:64] != 17'd0) && (m_tdata[80:64] <= 17'd65536))
        else $error("count out of range");

    // a single sample gives the one-LSB deviation and a whole mean
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[80:64] == 17'd1)
            |-> (m_tdata[63:32] == 32'd1) && (m_tdata[15:0] == 16'd0))
        else $error("single-sample result wrong");

endmodule

bind running_mean_stdev rms_checker u_rms_checker (.*);

// ----- sim/running_mean_stdev_tb.sv -----
// Self-checking testbench of the streaming mean and sample deviation block.
`timescale 1ns / 100ps

// Predicts each series result and matches it against the result stream.
class series_stats_board;
    int unsigned         held_count;
    longint              held_sum;
    longint unsigned     held_sum_sq;
    bit                  held_dropped;
    rms_pkg::rms_res_t   awaited[$];
    int                  errors;

    function new();
        held_count   = 0;
        held_sum     = 0;
        held_sum_sq  = 0;
        held_dropped = 0;
        errors       = 0;
    endfunction

    // Floor of sum * 2^16 / n, kept to 32 bits
    function logic [31:0] fixed_mean(longint s, int unsigned n);
        longint          scaled;
        longint          quot;
        longint unsigned mag;
        longint unsigned nn;
        scaled = s * 64'sd65536;
        nn     = n;
        if (scaled >= 0) begin
            quot = scaled / longint'(nn);
        end else begin
            mag  = longint'(-scaled);
            quot = -longint'((mag + nn - 1) / nn);
        end
        return quot[31:0];
    endfunction

    // Largest r with r*r <= v, built one bit at a time from the top
    function logic [31:0] floor_root(longint unsigned v);
        longint unsigned root;
        longint unsigned cand;
        root = 0;
        for (int i = 31; i >= 0; i--) begin
            cand = root | (64'd1 << i);
            if (cand * cand <= v)
                root = cand;
        end
        return root[31:0];
    endfunction

    // Sample deviation with 16 fractional bits, never below one LSB
    function logic [31:0] fixed_stdev(longint s, longint unsigned sq, int unsigned n);
        longint unsigned mag;
        longint unsigned spread;
        longint unsigned pairs;
        longint unsigned quot;
        longint unsigned rem;
        longint unsigned var_fx;
        logic [31:0]     root;
        if (n < 2)
            return rms_pkg::STDEV_FLOOR;
        mag    = (s < 0) ? longint'(-s) : longint'(s);
        spread = longint'(n) * sq;
        if (spread <= mag * mag)
            return rms_pkg::STDEV_FLOOR;
        spread = spread - mag * mag;
        pairs  = longint'(n) * longint'(n - 1);
        quot   = spread / pairs;
        rem    = spread % pairs;
        var_fx = (quot << 32) + ((rem << 32) / pairs);
        root   = floor_root(var_fx);
        if (root == 0)
            root = rms_pkg::STDEV_FLOOR;
        return root;
    endfunction

    // Fold one accepted sample into the series; queue a result on the last one
    function void note_sample(logic [15:0] raw, logic is_last);
        longint            v;
        rms_pkg::rms_res_t res;
        v = longint'($signed(raw));
        if (held_count < rms_pkg::MAX_SAMPLES) begin
            held_count++;
            held_sum    += v;
            held_sum_sq += longint'(v * v);
        end else begin
            held_dropped = 1;
        end
        if (is_last) begin
            res.mean     = fixed_mean(held_sum, held_count);
            res.stdev    = fixed_stdev(held_sum, held_sum_sq, held_count);
            res.count    = held_count[16:0];
            res.overflow = held_dropped;
            awaited      = {awaited, res};
            held_count   = 0;
            held_sum     = 0;
            held_sum_sq  = 0;
            held_dropped = 0;
        end
    endfunction

    // Compare one accepted result item with the oldest awaited one
    function void check_result(logic [87:0] data);
        rms_pkg::rms_res_t exp_res;
        if (awaited.size() == 0) begin
            $error("result item with no series pending: %h", data);
            errors++;
            return;
        end
        exp_res = awaited.pop_front();
        if (data[31:0] !== exp_res.mean) begin
            $error("mean: expected %h, got %h", exp_res.mean, data[31:0]);
            errors++;
        end
        if (data[63:32] !== exp_res.stdev) begin
            $error("stdev: expected %h, got %h", exp_res.stdev, data[63:32]);
            errors++;
        end
        if (data[80:64] !== exp_res.count) begin
            $error("count: expected %h, got %h", exp_res.count, data[80:64]);
            errors++;
        end
        if (data[81] !== exp_res.overflow) begin
            $error("overflow: expected %b, got %b", exp_res.overflow, data[81]);
            errors++;
        end
    endfunction
endclass

module running_mean_stdev_tb;
    import rms_pkg::*;

    // Kinds of series content for the random part
    typedef enum int {
        MIX_FULL,   // any 16-bit value
        MIX_EDGE,   // extremes and values around zero
        MIX_FLAT,   // one value repeated, zero spread
        MIX_NEAR    // small spread around a random base
    } series_mix_t;

    localparam int TAIL_CYCLES = 250;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;

    // Idling switches; cleared for stretches of back-to-back traffic
    bit stall_in  = 1'b1;
    bit stall_out = 1'b1;

    series_stats_board board = new();

    running_mean_stdev dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Present one sample, hold it until accepted, then note it for prediction
    task automatic send_sample(input logic [15:0] value, input logic is_last);
        int gap;
        gap = stall_in ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        board.note_sample(value, is_last);
    endtask

    // Drop valid and hold off until every pending series has reported
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.awaited.size() != 0);
    endtask

    function automatic logic [15:0] draw_sample(series_mix_t mix, logic [15:0] base);
        logic [15:0] pick;
        case (mix)
            MIX_FULL: begin
                pick = 16'($urandom);
            end
            MIX_EDGE: begin
                case ($urandom_range(0, 5))
                    0: pick = 16'h8000;
                    1: pick = 16'h7FFF;
                    2: pick = 16'h0000;
                    3: pick = 16'hFFFF;
                    4: pick = 16'h8001;
                    default: pick = 16'h0001;
                endcase
            end
            MIX_FLAT: begin
                pick = base;
            end
            default: begin
                pick = base + 16'($urandom_range(0, 3));
            end
        endcase
        return pick;
    endfunction

    // Accept result items with random stalls and check each one
    initial begin
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            gap = stall_out ? $urandom_range(0, 19) : 0;
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_result(m_tdata);
        end
    end

    // Stimulus and verdict
    initial begin
        int          rand_items;
        int          rand_series;
        int          len;
        series_mix_t mix;
        logic [15:0] base;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Single-sample series: the deviation falls back to one LSB
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        // Widest possible pair: largest deviation
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b1);
        // Equal pair: zero deviation reported as one LSB
        send_sample(16'h1234, 1'b0);
        send_sample(16'h1234, 1'b1);
        // Short series: a negative fractional mean, then positive means
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h0002, 1'b0);
        send_sample(16'h0003, 1'b1);
        send_sample(16'hFFFB, 1'b0);
        send_sample(16'h0007, 1'b0);
        send_sample(16'h0064, 1'b1);
        drain_results();

        // Random series, mostly short, a few long
        rand_items  = 0;
        rand_series = 0;
        while (rand_items < 1100) begin
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(61, 300);
                1, 2:    len = $urandom_range(13, 60);
                default: len = $urandom_range(1, 12);
            endcase
            mix  = series_mix_t'($urandom_range(0, 3));
            base = 16'($urandom);
            // Switch idling off now and then for back-to-back stretches
            stall_in  = ($urandom_range(0, 3) != 0);
            stall_out = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < len; i++)
                send_sample(draw_sample(mix, base), i == len - 1);
            rand_items += len;
            rand_series++;
            if (rand_series == 30)
                drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.awaited.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #12_000_000;
        $display("Some tests failed");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/rms_pkg.sv
rtl/core/rms_front.sv
rtl/core/rms_queue.sv
rtl/core/rms_div.sv
rtl/core/rms_sqrt.sv
rtl/core/rms_back.sv
rtl/core/running_mean_stdev.sv
rtl/core/rms_checker.sv
sim/running_mean_stdev_tb.sv
